// ===== rtl/poi_pkg.sv =====
`timescale 1ns / 1ps
package poi_pkg;
	localparam int AtanEntries = 24;
	localparam logic signed [33:0] CordicGainInv = 34'sd652032874;
	localparam logic [29:0] TurnInvQ32 = 30'd683565276;
	localparam logic signed [47:0] PosMax = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] PosMin = 48'sh8000_0000_0000;

	function automatic logic [29:0] atan_entry(input logic [4:0] idx);
		logic [29:0] r;
		case (idx)
			5'd0: r = 30'd536870912;
			5'd1: r = 30'd316933406;
			5'd2: r = 30'd167458907;
			5'd3: r = 30'd85004756;
			5'd4: r = 30'd42667331;
			5'd5: r = 30'd21354465;
			5'd6: r = 30'd10680862;
			5'd7: r = 30'd5340245;
			5'd8: r = 30'd2670675;
			5'd9: r = 30'd1335343;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic [15:0] time_step;
		logic signed [23:0] vel_forward;
		logic signed [23:0] vel_lateral;
		logic signed [23:0] yaw_rate;
	} req_t;

	typedef struct packed {
		logic signed [47:0] pose_x;
		logic signed [47:0] pose_y;
		logic signed [31:0] pose_heading;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_z;
		logic signed [23:0] echo_forward;
		logic signed [23:0] echo_lateral;
		logic signed [23:0] echo_yaw_rate;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_LOAD  = 4'd0,
		OP_CSTART1 = 4'd1,
		OP_CITER = 4'd2,
		OP_RMUL  = 4'd3,
		OP_RRND  = 4'd4,
		OP_DMUL  = 4'd5,
		OP_ACC   = 4'd6,
		OP_HMUL  = 4'd7,
		OP_HMUL2 = 4'd8,
		OP_HADD  = 4'd9,
		OP_CSTART2 = 4'd10,
		OP_QOUT  = 4'd11,
		OP_HMUL3 = 4'd12,
		OP_NONE  = 4'd13
	} op_t;

	typedef struct packed {
		op_t op;
		logic sel;
	} cmd_t;

	typedef struct packed {
		logic iter_done;
	} sts_t;
endpackage

// ===== rtl/poi_if.sv =====
`timescale 1ns / 1ps
interface poi_req_if import poi_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface poi_rsp_if import poi_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/poi_datapath.sv =====
`timescale 1ns / 1ps
module poi_datapath import poi_pkg::*; #(
	parameter int CORDIC_ITERS = 16
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input req_t req,
	output sts_t sts,
	output rsp_t rsp
);
	localparam int NIt = (CORDIC_ITERS < AtanEntries) ? CORDIC_ITERS : AtanEntries;

	req_t in_q;
	logic signed [47:0] acc_x_q, acc_y_q;
	logic [31:0] acc_h_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0] it_q;
	logic flip_q;
	logic signed [58:0] px_q, py_q;
	logic signed [59:0] rx_q, ry_q;
	logic signed [55:0] dx_q, dy_q;
	logic [39:0] pmag_q;
	logic pneg_q;
	logic [47:0] tlo_q;
	logic [55:0] r_q;
	logic signed [15:0] qw_q, qz_q;

	logic signed [33:0] xs, ys;
	logic signed [33:0] cxf, cyf;
	logic [29:0] at;
	logic signed [31:0] hs, hf;
	logic signed [33:0] ang;
	logic signed [17:0] qwr, qzr;
	logic signed [39:0] p;
	logic signed [32:0] dh;
	logic signed [49:0] sx, sy;
	logic signed [38:0] rxr, ryr;

	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign cxf = flip_q ? -cx_q : cx_q;
	assign cyf = flip_q ? -cy_q : cy_q;
	assign at = atan_entry(it_q);
	assign hs = $signed(acc_h_q);
	assign hf = hs >>> 1;
	assign p = $signed({16'd0, in_q.time_step}) * in_q.yaw_rate;
	assign dh = pneg_q ? -$signed({1'b0, r_q[47:16]}) : $signed({1'b0, r_q[47:16]});
	assign qwr = 18'((cx_q + 34'sd32768) >>> 16);
	assign qzr = 18'((cy_q + 34'sd32768) >>> 16);
	assign rxr = 39'((rx_q + 60'sd2097152) >>> 22);
	assign ryr = 39'((ry_q + 60'sd2097152) >>> 22);
	assign sx = 50'(acc_x_q) + 50'((dx_q + 56'sd32768) >>> 16);
	assign sy = 50'(acc_y_q) + 50'((dy_q + 56'sd32768) >>> 16);
	assign sts.iter_done = (it_q == 5'(NIt - 1));

	always_comb begin
		ang = 34'(hs);
		if (hs > 32'sd1073741824) ang = 34'(hs) - 34'sd2147483648;
		else if (hs < -32'sd1073741824) ang = 34'(hs) + 34'sd2147483648;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_h_q <= '0;
		end else begin
			case (cmd.op)
				OP_ACC: begin
					acc_x_q <= (sx > 50'(PosMax)) ? PosMax : (sx < 50'(PosMin)) ? PosMin : 48'(sx);
					acc_y_q <= (sy > 50'(PosMax)) ? PosMax : (sy < 50'(PosMin)) ? PosMin : 48'(sy);
				end
				OP_HADD: acc_h_q <= acc_h_q + 32'(dh);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: in_q <= req;
			OP_CSTART1: begin
				cx_q <= CordicGainInv; cy_q <= '0; cz_q <= ang; it_q <= '0;
				flip_q <= (hs > 32'sd1073741824) || (hs < -32'sd1073741824);
			end
			OP_CSTART2: begin
				cx_q <= CordicGainInv; cy_q <= '0; cz_q <= 34'(hf); it_q <= '0;
			end
			OP_CITER: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - 34'(at);
				end else begin
					cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + 34'(at);
				end
				it_q <= it_q + 5'd1;
			end
			OP_RMUL: begin
				cx_q <= cxf; cy_q <= cyf;
				flip_q <= 1'b0;
				if (!cmd.sel) begin
					px_q <= cxf * in_q.vel_forward; py_q <= cyf * in_q.vel_lateral;
				end else begin
					px_q <= cyf * in_q.vel_forward; py_q <= cxf * in_q.vel_lateral;
				end
			end
			OP_RRND: begin
				if (!cmd.sel) rx_q <= 60'(px_q) - 60'(py_q);
				else ry_q <= 60'(px_q) + 60'(py_q);
			end
			OP_DMUL: begin
				dx_q <= 56'(rxr) * $signed({40'd0, in_q.time_step});
				dy_q <= 56'(ryr) * $signed({40'd0, in_q.time_step});
			end
			OP_HMUL: begin
				pneg_q <= p[39];
				pmag_q <= p[39] ? 40'(-p) : 40'(p);
			end
			OP_HMUL2: begin
				tlo_q <= 48'(pmag_q[15:0]) * 48'(TurnInvQ32) + 48'h8000_0000;
			end
			OP_HMUL3: begin
				r_q <= 56'(pmag_q[39:16]) * 56'(TurnInvQ32) + 56'(tlo_q[47:16]);
			end
			OP_QOUT: begin
				qw_q <= (qwr > 18'sd32767) ? 16'sh7FFF : (qwr < -18'sd32768) ? 16'sh8000 : 16'(qwr);
				qz_q <= (qzr > 18'sd32767) ? 16'sh7FFF : (qzr < -18'sd32768) ? 16'sh8000 : 16'(qzr);
			end
			default: ;
		endcase
	end

	assign rsp.pose_x = acc_x_q;
	assign rsp.pose_y = acc_y_q;
	assign rsp.pose_heading = $signed(acc_h_q);
	assign rsp.quat_w = qw_q;
	assign rsp.quat_z = qz_q;
	assign rsp.echo_forward = in_q.vel_forward;
	assign rsp.echo_lateral = in_q.vel_lateral;
	assign rsp.echo_yaw_rate = in_q.yaw_rate;
endmodule

// ===== rtl/poi_ctrl.sv =====
`timescale 1ns / 1ps
module poi_ctrl import poi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_C1   = 14'b00000000000010,
		S_IT1  = 14'b00000000000100,
		S_MX   = 14'b00000000001000,
		S_RX   = 14'b00000000010000,
		S_MY   = 14'b00000000100000,
		S_RY   = 14'b00000001000000,
		S_DM   = 14'b00000010000000,
		S_AC   = 14'b00000100000000,
		S_H1   = 14'b00001000000000,
		S_H2   = 14'b00010000000000,
		S_H3   = 14'b00100000000000,
		S_HA   = 14'b01000000000000,
		S_Q    = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic second_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd = '{op: OP_NONE, sel: 1'b0};
		case (state_q)
			S_IDLE: cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
			S_C1: cmd.op = second_q ? OP_CSTART2 : OP_CSTART1;
			S_IT1: cmd.op = OP_CITER;
			S_MX: cmd.op = OP_RMUL;
			S_RX: cmd.op = OP_RRND;
			S_MY: cmd = '{op: OP_RMUL, sel: 1'b1};
			S_RY: cmd = '{op: OP_RRND, sel: 1'b1};
			S_DM: cmd.op = OP_DMUL;
			S_AC: cmd.op = OP_ACC;
			S_H1: cmd.op = OP_HMUL;
			S_H2: cmd.op = OP_HMUL2;
			S_H3: cmd.op = OP_HMUL3;
			S_HA: cmd.op = OP_HADD;
			S_Q: cmd.op = OP_QOUT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			second_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					state_q <= S_C1; second_q <= 1'b0;
				end
				S_C1: state_q <= S_IT1;
				S_IT1: if (sts.iter_done) state_q <= second_q ? S_Q : S_MX;
				S_MX: state_q <= S_RX;
				S_RX: state_q <= S_MY;
				S_MY: state_q <= S_RY;
				S_RY: state_q <= S_DM;
				S_DM: state_q <= S_AC;
				S_AC: state_q <= S_H1;
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: state_q <= S_HA;
				S_HA: begin state_q <= S_C1; second_q <= 1'b1; end
				S_Q: begin state_q <= S_IDLE; out_valid <= 1'b1; end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/planar_odometry_integrator.sv =====
`timescale 1ns / 1ps
// channel | dir | payload                                    | handshake
// req     | in  | time_step, vel_forward, vel_lateral, yaw    | valid/ready
// rsp     | out | pose x/y/heading, quat w/z, echoed velocity | valid/ready
// A response depends on N, being CORDIC_ITERS capped at 24, the iteration count
// of the shared CORDIC unit, which runs once for the old heading and once for the
// half heading. A new request is taken once the previous response has been
// taken, so requests are handled one at a time.
// Reset clears the pose to zero.
module planar_odometry_integrator import poi_pkg::*; #(
	parameter int CORDIC_ITERS = 16
) (
	input logic clk,
	input logic arst_n,
	poi_req_if.sink req,
	poi_rsp_if.source rsp
);
	cmd_t cmd;
	sts_t sts;

	poi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	poi_datapath #(.CORDIC_ITERS(CORDIC_ITERS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .req(req.payload), .sts(sts), .rsp(rsp.payload)
	);
endmodule

// ===== tb/sv/tb_planar_odometry_integrator.sv =====
`timescale 1ns / 1ps
module tb_planar_odometry_integrator;
	import poi_pkg::*;

	localparam int Iters = 16;
	localparam longint CycleLimit = 64'd9000000;
	localparam longint unsigned TurnInv = 64'd683565276;
	localparam longint GainInv = 64'sd652032874;
	localparam logic signed [23:0] VelMax = 24'sh7FFFFF;
	localparam logic signed [23:0] VelMin = 24'sh800000;

	typedef enum int {
		ROW_PLAIN,
		ROW_COARSE,
		ROW_FINE
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [15:0] dt;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic signed [23:0] wz;
		bit chk_xy;
		bit chk_h;
		bit chk_q;
		logic signed [47:0] ex;
		logic signed [47:0] ey;
		logic signed [31:0] eh;
		logic signed [15:0] eqw;
		logic signed [15:0] eqz;
	} stim_row_t;

	logic clk;
	logic arst_n;
	poi_req_if req ();
	poi_rsp_if rsp ();

	planar_odometry_integrator #(.CORDIC_ITERS(Iters)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	longint atan_lut [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10680862, 5340245, 2670675, 1335343, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	longint pos_x;
	longint pos_y;
	logic [31:0] heading;
	rsp_t pose_q [$];
	stim_row_t rows [$];
	bit failed;
	bit idle_en;
	bit hold_req;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp48(longint v);
		if (v > longint'(PosMax)) return longint'(PosMax);
		if (v < longint'(PosMin)) return longint'(PosMin);
		return v;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	task automatic rotate(input longint angle, output longint c, output longint s);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		x = GainInv;
		y = 0;
		z = angle;
		for (int i = 0; i < Iters && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - atan_lut[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + atan_lut[i];
			end
		end
		c = x;
		s = y;
	endtask

	function automatic longint turn_delta(logic signed [23:0] wz, logic [15:0] dt);
		longint p;
		longint unsigned mag;
		longint unsigned t;
		longint unsigned r;
		p = longint'(wz) * longint'({1'b0, dt});
		mag = (p < 0) ? longint'(-p) : p;
		t = (mag & 64'hFFFF) * TurnInv + (64'd1 << 31);
		r = ((mag >> 16) * TurnInv + (t >> 16)) >> 16;
		return (p < 0) ? -longint'(r) : longint'(r);
	endfunction

	task automatic integrate(input req_t r, output rsp_t o);
		longint ang;
		longint c;
		longint s;
		longint rx;
		longint ry;
		longint dt;
		longint qw;
		longint qz;
		bit flip;
		dt = longint'({1'b0, r.time_step});
		ang = longint'($signed(heading));
		flip = 1'b0;
		if (ang > (64'sd1 <<< 30)) begin
			ang = ang - (64'sd1 <<< 31);
			flip = 1'b1;
		end else if (ang < -(64'sd1 <<< 30)) begin
			ang = ang + (64'sd1 <<< 31);
			flip = 1'b1;
		end
		rotate(ang, c, s);
		if (flip) begin
			c = -c;
			s = -s;
		end
		rx = longint'(r.vel_forward) * c - longint'(r.vel_lateral) * s;
		ry = longint'(r.vel_forward) * s + longint'(r.vel_lateral) * c;
		pos_x = clamp48(pos_x + rnd_shift(rnd_shift(rx, 22) * dt, 16));
		pos_y = clamp48(pos_y + rnd_shift(rnd_shift(ry, 22) * dt, 16));
		heading = heading + 32'(turn_delta(r.yaw_rate, r.time_step));
		rotate(longint'($signed(heading)) >>> 1, qw, qz);
		o.pose_x = pos_x[47:0];
		o.pose_y = pos_y[47:0];
		o.pose_heading = heading;
		o.quat_w = 16'(clamp16(rnd_shift(qw, 16)));
		o.quat_z = 16'(clamp16(rnd_shift(qz, 16)));
		o.echo_forward = r.vel_forward;
		o.echo_lateral = r.vel_lateral;
		o.echo_yaw_rate = r.yaw_rate;
	endtask

	task automatic send(input req_t r, input stim_row_t row, input bit typed);
		rsp_t o;
		req.valid <= 1'b1;
		req.payload <= r;
		do @(posedge clk); while (!req.ready);
		integrate(r, o);
		if (typed) begin
			if (row.chk_xy) begin
				o.pose_x = row.ex;
				o.pose_y = row.ey;
			end
			if (row.chk_h) o.pose_heading = row.eh;
			if (row.chk_q) begin
				o.quat_w = row.eqw;
				o.quat_z = row.eqz;
			end
		end
		pose_q.push_back(o);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic send_row(input stim_row_t row);
		req_t r;
		longint rem;
		longint w;
		r.time_step = row.dt;
		r.vel_forward = row.vx;
		r.vel_lateral = row.vy;
		r.yaw_rate = row.wz;
		rem = longint'({32'd0, 32'h8000_0000 - heading});
		if (row.kind == ROW_COARSE) begin
			w = longint'($floor(real'(rem) * 6.283185307 / 65535.0)) - 2;
			if (w < 0) w = 0;
			if (w > 8388607) w = 8388607;
			r.time_step = 16'hFFFF;
			r.yaw_rate = 24'(w);
		end else if (row.kind == ROW_FINE) begin
			w = longint'($floor(real'(rem) * 6.283185307)) - 4;
			if (w < 0) w = 0;
			while (turn_delta(24'(w), 16'd1) < rem) w++;
			r.time_step = 16'd1;
			r.yaw_rate = 24'(w);
		end
		send(r, row, 1'b1);
	endtask

	task automatic add_row(input row_kind_t kind, input logic [15:0] dt,
			input logic signed [23:0] vx, input logic signed [23:0] vy,
			input logic signed [23:0] wz, input bit chk_xy, input bit chk_h,
			input bit chk_q, input logic signed [31:0] eh);
		stim_row_t row;
		row.kind = kind;
		row.dt = dt;
		row.vx = vx;
		row.vy = vy;
		row.wz = wz;
		row.chk_xy = chk_xy;
		row.chk_h = chk_h;
		row.chk_q = chk_q;
		row.ex = '0;
		row.ey = '0;
		row.eh = eh;
		row.eqw = 16'sd0;
		row.eqz = -16'sd16384;
		rows.push_back(row);
	endtask

	function automatic logic signed [23:0] rand_vel();
		case ($urandom_range(0, 5))
			0: return VelMax;
			1: return VelMin;
			2: return 24'($signed($urandom_range(0, 2000)) - 1000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_dt();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 700));
			default: return 16'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (rsp.valid && rsp.ready) begin
			if (pose_q.size() == 0) begin
				$error("response with nothing pending");
				failed = 1'b1;
			end else begin
				e = pose_q.pop_front();
				if (rsp.payload.pose_x !== e.pose_x) begin
					$error("pose_x exp %0d got %0d", e.pose_x, rsp.payload.pose_x);
					failed = 1'b1;
				end
				if (rsp.payload.pose_y !== e.pose_y) begin
					$error("pose_y exp %0d got %0d", e.pose_y, rsp.payload.pose_y);
					failed = 1'b1;
				end
				if (rsp.payload.pose_heading !== e.pose_heading) begin
					$error("pose_heading exp %0d got %0d", e.pose_heading,
						rsp.payload.pose_heading);
					failed = 1'b1;
				end
				if (rsp.payload.quat_w !== e.quat_w) begin
					$error("quat_w exp %0d got %0d", e.quat_w, rsp.payload.quat_w);
					failed = 1'b1;
				end
				if (rsp.payload.quat_z !== e.quat_z) begin
					$error("quat_z exp %0d got %0d", e.quat_z, rsp.payload.quat_z);
					failed = 1'b1;
				end
				if (rsp.payload.echo_forward !== e.echo_forward) begin
					$error("echo_forward exp %0d got %0d", e.echo_forward,
						rsp.payload.echo_forward);
					failed = 1'b1;
				end
				if (rsp.payload.echo_lateral !== e.echo_lateral) begin
					$error("echo_lateral exp %0d got %0d", e.echo_lateral,
						rsp.payload.echo_lateral);
					failed = 1'b1;
				end
				if (rsp.payload.echo_yaw_rate !== e.echo_yaw_rate) begin
					$error("echo_yaw_rate exp %0d got %0d", e.echo_yaw_rate,
						rsp.payload.echo_yaw_rate);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		int long_hold;
		int idle_left;
		long_hold = 0;
		idle_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				long_hold = 400;
			end
			if (long_hold > 0) begin
				long_hold--;
				rsp.ready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				rsp.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				idle_left = $urandom_range(0, 16);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		req_t r;
		stim_row_t blank;
		failed = 1'b0;
		idle_en = 1'b1;
		hold_req = 1'b0;
		cycles = 0;
		pos_x = 0;
		pos_y = 0;
		heading = '0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.payload = '0;
		blank = '{kind: ROW_PLAIN, default: '0};

		add_row(ROW_PLAIN, 16'd0, 24'sd0, 24'sd0, 24'sd0, 1, 1, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'd0, VelMax, VelMin, VelMax, 1, 1, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'd0, VelMin, VelMax, VelMin, 1, 1, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'hFFFF, VelMax, 24'sd0, 24'sd0, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'hFFFF, VelMin, VelMin, 24'sd0, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'd1, 24'sd1, -24'sd1, 24'sd1, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'hFFFF, 24'sd0, 24'sd0, VelMax, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'hFFFF, 24'sd0, 24'sd0, VelMin, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'hFFFF, VelMax, VelMax, VelMax, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'h8000, -24'sd1, 24'sd1, -24'sd1, 0, 0, 0, 32'sd0);
		add_row(ROW_COARSE, 16'd0, 24'sd0, 24'sd0, 24'sd0, 0, 0, 0, 32'sd0);
		add_row(ROW_FINE, 16'd0, 24'sd0, 24'sd0, 24'sd0, 0, 1, 1, 32'sh8000_0000);
		add_row(ROW_PLAIN, 16'd0, VelMax, VelMax, 24'sd0, 0, 1, 1, 32'sh8000_0000);
		add_row(ROW_PLAIN, 16'hFFFF, VelMax, VelMin, 24'sd0, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'hFFFF, 24'sd100, 24'sd0, VelMax, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'hFFFF, 24'sd0, 24'sd100, VelMax, 0, 0, 0, 32'sd0);
		add_row(ROW_PLAIN, 16'hFFFF, 24'sd0, 24'sd0, VelMax, 0, 0, 0, 32'sd0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_row(rows[i]);

		for (int n = 0; n < 500; n++) begin
			r.time_step = rand_dt();
			r.vel_forward = rand_vel();
			r.vel_lateral = rand_vel();
			r.yaw_rate = rand_vel();
			if (n == 150) begin
				hold_req = 1'b1;
			end
			if (n == 300) begin
				req.valid <= 1'b0;
				wait (pose_q.size() == 0);
				@(posedge clk);
			end
			send(r, blank, 1'b0);
		end

		// drive heading back to -pi, then run flat out at full speed
		idle_en = 1'b0;
		send_row(rows[10]);
		send_row(rows[11]);
		r.time_step = 16'hFFFF;
		r.vel_forward = VelMax;
		r.vel_lateral = VelMax;
		r.yaw_rate = 24'sd0;
		for (int n = 0; n < 20; n++) send(r, blank, 1'b0);
		req.valid <= 1'b0;

		wait (pose_q.size() == 0);
		repeat (2 * Iters + 40) @(posedge clk);
		if (!failed && pose_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
